// File: design/fba_pkg.sv
package fba_pkg;

	typedef struct packed {
		logic side_right;
		logic centre_right;
		logic side_left;
		logic centre_left;
		logic box_tamper;
	} tick_t;

	typedef struct packed {
		logic [13:0] alarm_code;
		logic        alert_flag;
		logic [7:0]  sender_id;
		logic        last_report;
	} report_t;

	localparam int CNT_W  = 16;
	localparam int CODE_W = 14;
	localparam int ID_W   = 8;
	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 16;
	localparam logic [CFG_IDX_W-1:0] CFG_BREACH    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HEARTBEAT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_NODE_ID   = 2'd2;

	localparam logic [CNT_W-1:0] BREACH_RST    = 16'd4000;
	localparam logic [CNT_W-1:0] HEARTBEAT_RST = 16'd2000;
	localparam logic [ID_W-1:0]  NODE_ID_RST   = 8'd66;

	localparam logic [1:0] KIND_LEFT  = 2'd0;
	localparam logic [1:0] KIND_RIGHT = 2'd1;
	localparam logic [1:0] KIND_BOX   = 2'd2;
	localparam logic [1:0] KIND_BEAT  = 2'd3;

	localparam logic [CODE_W-1:0] CODE_MIN = 14'd13200;
	localparam logic [CODE_W-1:0] CODE_MAX = 14'd13508;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);

	// one accepted tick that produced at least one report
	typedef struct packed {
		logic [1:0]        n_chg;
		logic              evt;
		logic [CODE_W-1:0] code_pre;
		logic              alert_pre;
		logic [CODE_W-1:0] code_post;
		logic              alert_post;
		logic [ID_W-1:0]   sender;
	} q_entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	function automatic logic [CODE_W-1:0] trig_base(input logic [1:0] kind);
		logic [CODE_W-1:0] b;
		case (kind)
			KIND_LEFT:  b = 14'd13200;
			KIND_RIGHT: b = 14'd13300;
			KIND_BOX:   b = 14'd13400;
			KIND_BEAT:  b = 14'd13500;
			default:    b = 14'd13500;
		endcase
		return b;
	endfunction

endpackage

// File: design/fba_front.sv
module fba_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          tick_valid,
	output logic                          tick_ready,
	input  fba_pkg::tick_t                tick,
	input  logic                          cfg_wr,
	input  logic [fba_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [fba_pkg::CFG_DAT_W-1:0] cfg_data,
	input  logic                          q_full,
	output logic                          q_push,
	output fba_pkg::q_entry_t             q_wdata
);
	import fba_pkg::*;

	logic [CNT_W-1:0] breach_q, heartbeat_q;
	logic [ID_W-1:0]  node_id_q;

	logic             right_prev_q, left_prev_q, alert_q;
	logic [1:0]       kind_q;
	logic [CNT_W-1:0] right_el_q, left_el_q, quiet_el_q;

	logic             r, l, box, chg_r, chg_l;
	logic             raise_l, raise_r, raise_b, raise, drop, any_early, beat;
	logic [CNT_W-1:0] right_inc, left_inc, quiet_inc, right_nx, left_nx, quiet_nx;
	logic [1:0]       kind_nx;
	logic             alert_nx;
	logic [3:0]       add;
	logic             accept;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		return (v == CNT_MAX) ? v : v + 1'b1;
	endfunction

	assign tick_ready = !q_full;
	assign accept     = tick_valid && tick_ready;

	always_comb begin
		r   = !(tick.side_right && !tick.centre_right);
		l   = !(tick.side_left && !tick.centre_left);
		box = tick.box_tamper;

		right_inc = sat_inc(right_el_q);
		left_inc  = sat_inc(left_el_q);
		quiet_inc = sat_inc(quiet_el_q);

		chg_r = r != right_prev_q;
		chg_l = l != left_prev_q;
		// entering alarm restarts the side's timer
		right_nx = (chg_r && r) ? '0 : right_inc;
		left_nx  = (chg_l && l) ? '0 : left_inc;

		raise_l = l && !alert_q && (left_nx > breach_q);
		raise_r = r && !alert_q && !raise_l && (right_nx > breach_q);
		raise_b = box && !alert_q && !raise_l && !raise_r;
		raise   = raise_l || raise_r || raise_b;
		drop    = !box && !l && !r && alert_q;

		any_early = chg_r || chg_l || raise || drop;
		beat      = !any_early && (quiet_inc > heartbeat_q);
		quiet_nx  = (any_early || beat) ? '0 : quiet_inc;

		if (raise_l) kind_nx = KIND_LEFT;
		else if (raise_r) kind_nx = KIND_RIGHT;
		else if (raise_b) kind_nx = KIND_BOX;
		else if (beat) kind_nx = KIND_BEAT;
		else kind_nx = kind_q;

		if (raise) alert_nx = 1'b1;
		else if (drop) alert_nx = 1'b0;
		else alert_nx = alert_q;

		add = {3'd0, l} + {2'd0, r, 1'b0} + (box ? 4'd5 : 4'd0);

		q_wdata.n_chg      = {1'b0, chg_r} + {1'b0, chg_l};
		q_wdata.evt        = raise || drop || beat;
		q_wdata.code_pre   = trig_base(kind_q) + {{(CODE_W-4){1'b0}}, add};
		q_wdata.alert_pre  = alert_q;
		q_wdata.code_post  = trig_base(kind_nx) + {{(CODE_W-4){1'b0}}, add};
		q_wdata.alert_post = alert_nx;
		q_wdata.sender     = node_id_q;
	end

	assign q_push = accept && (any_early || beat);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			breach_q     <= BREACH_RST;
			heartbeat_q  <= HEARTBEAT_RST;
			node_id_q    <= NODE_ID_RST;
			right_prev_q <= 1'b0;
			left_prev_q  <= 1'b0;
			alert_q      <= 1'b0;
			kind_q       <= KIND_BEAT;
			right_el_q   <= '0;
			left_el_q    <= '0;
			quiet_el_q   <= '0;
		end else begin
			if (cfg_wr) begin
				case (cfg_index)
					CFG_BREACH:    breach_q <= cfg_data;
					CFG_HEARTBEAT: heartbeat_q <= cfg_data;
					CFG_NODE_ID:   node_id_q <= cfg_data[ID_W-1:0];
					default:       ;
				endcase
			end
			if (accept) begin
				right_prev_q <= r;
				left_prev_q  <= l;
				alert_q      <= alert_nx;
				kind_q       <= kind_nx;
				right_el_q   <= right_nx;
				left_el_q    <= left_nx;
				quiet_el_q   <= quiet_nx;
			end
		end
	end

endmodule

// File: design/fba_queue.sv
module fba_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  fba_pkg::q_entry_t wdata,
	input  logic              pop,
	output fba_pkg::q_entry_t rdata,
	output fba_pkg::q_stat_t  stat
);
	import fba_pkg::*;

	q_entry_t            entries_q [QDEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [QPTR_W:0]     count_q;

	assign stat.full  = count_q == QDEPTH[QPTR_W:0];
	assign stat.empty = count_q == '0;
	assign rdata      = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) entries_q[wr_ptr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: ;
			endcase
		end
	end

endmodule

// File: design/fba_back.sv
module fba_back (
	input  logic              clk,
	input  logic              arst_n,
	input  fba_pkg::q_entry_t head,
	input  logic              q_empty,
	output logic              q_pop,
	output logic              report_valid,
	input  logic              report_ready,
	output fba_pkg::report_t  report
);
	import fba_pkg::*;

	logic       out_valid_q;
	report_t    out_q;
	logic [1:0] idx_q;
	logic [1:0] total;
	logic       load, is_last, use_pre;

	assign total   = head.n_chg + {1'b0, head.evt};
	assign is_last = idx_q == total - 2'd1;
	// change reports come first and see the state from before the tick
	assign use_pre = idx_q < head.n_chg;
	assign load    = !q_empty && (!out_valid_q || report_ready);
	assign q_pop   = load && is_last;

	assign report_valid = out_valid_q;
	assign report       = out_q;

	always_ff @(posedge clk) begin
		if (load) begin
			out_q.alarm_code  <= use_pre ? head.code_pre : head.code_post;
			out_q.alert_flag  <= use_pre ? head.alert_pre : head.alert_post;
			out_q.sender_id   <= head.sender;
			out_q.last_report <= is_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q       <= '0;
		end else begin
			if (load) out_valid_q <= 1'b1;
			else if (report_ready) out_valid_q <= 1'b0;
			if (load) idx_q <= is_last ? 2'd0 : idx_q + 2'd1;
		end
	end

endmodule

// File: design/fence_breach_alarm_reporter.sv
// fence breach alarm reporter
// tick channel (tick_valid/tick_ready/tick): one millisecond tick per item with the four
// fence switch levels and the box tamper level. a tick is taken every cycle unless the
// four-entry queue between the classifier and the report generator is full.
// report channel (report_valid/report_ready/report): zero to three reports per tick,
// in order right change, left change, alert raise/drop or heartbeat; last_report marks
// the final report of a tick. a tick with no report produces nothing on this channel.
// cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data): always ready; index 0 breach
// ticks, 1 heartbeat ticks, 2 node id; other indexes are ignored. write only when idle.
// the first report of a tick passes two register stages, the queue and the output
// register, before it is on report. the report generator sends one report per cycle
// while report_ready is high. when report_ready is low the output register holds its
// report, the queue fills and tick_ready drops once four ticks with reports
// are waiting.
// reset: alarms clear, alert dropped, trigger kind heartbeat, all timers zero,
// registers back to 4000, 2000 and 66; the queue and output register empty.
module fence_breach_alarm_reporter (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          tick_valid,
	output logic                          tick_ready,
	input  fba_pkg::tick_t                tick,
	output logic                          report_valid,
	input  logic                          report_ready,
	output fba_pkg::report_t              report,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [fba_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [fba_pkg::CFG_DAT_W-1:0] cfg_data
);
	import fba_pkg::*;

	q_stat_t  q_stat;
	q_entry_t q_wdata, q_head;
	logic     q_push, q_pop;

	assign cfg_ready = 1'b1;

	fba_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.tick_valid (tick_valid),
		.tick_ready (tick_ready),
		.tick       (tick),
		.cfg_wr     (cfg_valid && cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.q_full     (q_stat.full),
		.q_push     (q_push),
		.q_wdata    (q_wdata)
	);

	fba_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.pop    (q_pop),
		.rdata  (q_head),
		.stat   (q_stat)
	);

	fba_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (q_head),
		.q_empty      (q_stat.empty),
		.q_pop        (q_pop),
		.report_valid (report_valid),
		.report_ready (report_ready),
		.report       (report)
	);

`ifndef NO_ASSERTIONS
	a_code_range: assert property (@(posedge clk) disable iff (!arst_n)
		report_valid |-> (report.alarm_code >= CODE_MIN && report.alarm_code <= CODE_MAX))
		else $error("report code out of range");

	// a tick's entry stays queued until its last report is loaded
	a_partial_tick: assert property (@(posedge clk) disable iff (!arst_n)
		(report_valid && !report.last_report) |-> !q_stat.empty)
		else $error("partial tick with empty queue");

	a_queue_stat: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_stat.full && q_stat.empty))
		else $error("queue full and empty");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_stat.full |-> !q_push)
		else $error("push into full queue");
`endif

endmodule
